// File: rtl/core/iic_pkg.sv
// iic_pkg: shared constants and state codes for the intensity centroid block
// no dependencies
`timescale 1ns / 1ps

package iic_pkg;

  localparam int PIXEL_IN_BITS   = 16;
  localparam int CFG_BITS        = 13;
  localparam int CENTER_BITS     = 20;
  localparam int OUT_WEIGHT_BITS = 40;

  localparam logic [CFG_BITS-1:0] WIDTH_RESET = 13'd4096;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_OUT  = 3'b100
  } back_state_t;

endpackage

// File: rtl/core/iic_if.sv
// iic_pix_if and iic_res_if: pixel request channel and centroid result channel
// depends on iic_pkg
`timescale 1ns / 1ps

interface iic_pix_if import iic_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [PIXEL_IN_BITS-1:0] pixel_value;
  logic                     frame_last;

  modport source (output valid, output pixel_value, output frame_last, input ready);
  modport sink   (input valid, input pixel_value, input frame_last, output ready);
endinterface

interface iic_res_if import iic_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CENTER_BITS-1:0]     center_x;
  logic [CENTER_BITS-1:0]     center_y;
  logic [OUT_WEIGHT_BITS-1:0] total_weight;
  logic                       empty_frame;

  modport source (output valid, output center_x, output center_y, output total_weight,
                  output empty_frame, input ready);
  modport sink   (input valid, input center_x, input center_y, input total_weight,
                  input empty_frame, output ready);
endinterface

// File: rtl/core/iic_front.sv
// iic_front: pixel intake, raster counters and weight/moment accumulation
// depends on iic_pkg and iic_if; pushes finished frame sums into iic_fifo
`timescale 1ns / 1ps

module iic_front import iic_pkg::*; #(
  parameter int PIXEL_BITS = 16,
  parameter int COORD_BITS = 12,
  parameter int QDEPTH     = 4,
  localparam int WB        = PIXEL_BITS + 2 * COORD_BITS,
  localparam int MB        = WB + COORD_BITS,
  localparam int QW        = WB + 2 * MB
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_BITS-1:0] cfg_wdata,
  input  logic                q_pop,
  output logic                q_push,
  output logic [QW-1:0]       q_wdata,
  iic_pix_if.sink             in_pix
);

  localparam int PW = PIXEL_BITS + COORD_BITS;
  localparam int CRB = $clog2(QDEPTH + 1);

  logic [CFG_BITS-1:0]   width_r;
  logic [COORD_BITS-1:0] col_r, row_r;
  logic                  a_valid_r, a_last_r;
  logic [PIXEL_BITS-1:0] a_pix_r;
  logic [COORD_BITS-1:0] a_col_r, a_row_r;
  logic                  b_valid_r, b_last_r;
  logic [PIXEL_BITS-1:0] b_pix_r;
  logic [PW-1:0]         b_px_r, b_py_r;
  logic [WB-1:0]         ws_r;
  logic [MB-1:0]         mx_r, my_r;
  logic [CRB-1:0]        credit_r, credit_nxt;

  logic                  accept;
  logic [CFG_BITS-1:0]   width_eff;
  logic [CFG_BITS-1:0]   col_inc;
  logic                  row_end;
  logic [WB-1:0]         ws_sum;
  logic [MB-1:0]         mx_sum, my_sum;

  assign in_pix.ready = (credit_r < CRB'(QDEPTH));
  assign accept       = in_pix.valid && in_pix.ready;

  // zero acts as one, wide rows saturate to the coordinate range
  always_comb begin
    if (width_r == '0) begin
      width_eff = CFG_BITS'(1);
    end else if (width_r > (CFG_BITS'(1) << COORD_BITS)) begin
      width_eff = CFG_BITS'(1) << COORD_BITS;
    end else begin
      width_eff = width_r;
    end
  end

  assign col_inc = CFG_BITS'(col_r) + CFG_BITS'(1);
  assign row_end = (col_inc >= width_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r <= WIDTH_RESET;
    end else if (cfg_we) begin
      width_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      if (in_pix.frame_last) begin
        col_r <= '0;
        row_r <= '0;
      end else if (row_end) begin
        col_r <= '0;
        row_r <= COORD_BITS'(row_r + 1'b1);
      end else begin
        col_r <= COORD_BITS'(col_inc);
      end
    end
  end

  // stage a: captured pixel and its coordinates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_pix_r  <= in_pix.pixel_value[PIXEL_BITS-1:0];
      a_col_r  <= col_r;
      a_row_r  <= row_r;
      a_last_r <= in_pix.frame_last;
    end
  end

  // stage b: moment products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid_r) begin
      b_pix_r  <= a_pix_r;
      b_px_r   <= PW'(a_pix_r) * PW'(a_col_r);
      b_py_r   <= PW'(a_pix_r) * PW'(a_row_r);
      b_last_r <= a_last_r;
    end
  end

  // stage c: accumulate, hand off the frame sums at the last pixel
  assign ws_sum  = ws_r + WB'(b_pix_r);
  assign mx_sum  = mx_r + MB'(b_px_r);
  assign my_sum  = my_r + MB'(b_py_r);
  assign q_push  = b_valid_r && b_last_r;
  assign q_wdata = {ws_sum, mx_sum, my_sum};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ws_r <= '0;
      mx_r <= '0;
      my_r <= '0;
    end else if (b_valid_r) begin
      if (b_last_r) begin
        ws_r <= '0;
        mx_r <= '0;
        my_r <= '0;
      end else begin
        ws_r <= ws_sum;
        mx_r <= mx_sum;
        my_r <= my_sum;
      end
    end
  end

  // one credit per frame end in flight or queued
  always_comb begin
    credit_nxt = credit_r;
    if (accept && in_pix.frame_last && !q_pop) begin
      credit_nxt = CRB'(credit_r + 1'b1);
    end else if (!(accept && in_pix.frame_last) && q_pop) begin
      credit_nxt = CRB'(credit_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      credit_r <= credit_nxt;
    end
  end

`ifndef SYNTH
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= CRB'(QDEPTH))
    else $error("frame credit count above queue depth");
`endif

endmodule

// File: rtl/core/iic_fifo.sv
// iic_fifo: short register queue of finished frame sums
// no dependencies
`timescale 1ns / 1ps

module iic_fifo #(
  parameter int WIDTH = 144,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic             full
);

  localparam int AB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CB = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AB-1:0]    wptr_r, rptr_r;
  logic [CB-1:0]    count_r;

  assign empty = (count_r == '0);
  assign full  = (count_r == CB'(DEPTH));
  assign rdata = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == AB'(DEPTH - 1)) ? '0 : AB'(wptr_r + 1'b1);
      end
      if (pop) begin
        rptr_r <= (rptr_r == AB'(DEPTH - 1)) ? '0 : AB'(rptr_r + 1'b1);
      end
      if (push && !pop) begin
        count_r <= CB'(count_r + 1'b1);
      end else if (pop && !push) begin
        count_r <= CB'(count_r - 1'b1);
      end
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("pop from empty queue");
`endif

endmodule

// File: rtl/core/iic_back.sv
// iic_back: per-frame centroid division and result register
// depends on iic_pkg and iic_if; takes frame sums from iic_fifo
`timescale 1ns / 1ps

module iic_back import iic_pkg::*; #(
  parameter int PIXEL_BITS = 16,
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 8,
  localparam int WB        = PIXEL_BITS + 2 * COORD_BITS,
  localparam int MB        = WB + COORD_BITS,
  localparam int QW        = WB + 2 * MB
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [QW-1:0] q_rdata,
  input  logic          q_empty,
  output logic          q_pop,
  iic_res_if.source     out_res
);

  localparam int NB  = MB + FRAC_BITS;
  localparam int RW  = WB + 1;
  localparam int SW  = NB + CENTER_BITS;
  localparam int CNB = $clog2(CENTER_BITS);

  back_state_t            state_r, state_nxt;
  logic [WB-1:0]          w_r;
  logic [RW-1:0]          remx_r, remy_r;
  logic [CENTER_BITS-1:0] lowx_r, lowy_r;
  logic [CENTER_BITS-1:0] qx_r, qy_r;
  logic                   satx_r, saty_r, empty_r;
  logic [CNB-1:0]         cnt_r;

  logic [WB-1:0]          in_w;
  logic [NB-1:0]          nx, ny;
  logic [RW:0]            stx, sty;

  // one restoring step: {new remainder, quotient bit}
  function automatic logic [RW:0] div_step(input logic [RW-1:0] rem, input logic bin,
                                           input logic [WB-1:0] w);
    logic [RW-1:0] t;
    begin
      t = {rem[RW-2:0], bin};
      if (t >= RW'(w)) begin
        div_step = {RW'(t - RW'(w)), 1'b1};
      end else begin
        div_step = {t, 1'b0};
      end
    end
  endfunction

  assign in_w = q_rdata[QW-1 -: WB];
  assign nx   = NB'(q_rdata[2*MB-1 -: MB]) << FRAC_BITS;
  assign ny   = NB'(q_rdata[MB-1:0]) << FRAC_BITS;
  assign stx  = div_step(remx_r, lowx_r[CENTER_BITS-1], w_r);
  assign sty  = div_step(remy_r, lowy_r[CENTER_BITS-1], w_r);
  assign q_pop = (state_r == S_IDLE) && !q_empty;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          state_nxt = (in_w == '0) ? S_OUT : S_DIV;
        end
      end
      S_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_res.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          w_r     <= in_w;
          empty_r <= (in_w == '0);
          satx_r  <= (in_w != '0) && (SW'(nx) >= (SW'(in_w) << CENTER_BITS));
          saty_r  <= (in_w != '0) && (SW'(ny) >= (SW'(in_w) << CENTER_BITS));
          remx_r  <= RW'(nx >> CENTER_BITS);
          remy_r  <= RW'(ny >> CENTER_BITS);
          lowx_r  <= nx[CENTER_BITS-1:0];
          lowy_r  <= ny[CENTER_BITS-1:0];
          qx_r    <= '0;
          qy_r    <= '0;
          cnt_r   <= CNB'(CENTER_BITS - 1);
        end
      end
      S_DIV: begin
        remx_r <= stx[RW:1];
        remy_r <= sty[RW:1];
        qx_r   <= {qx_r[CENTER_BITS-2:0], stx[0]};
        qy_r   <= {qy_r[CENTER_BITS-2:0], sty[0]};
        lowx_r <= {lowx_r[CENTER_BITS-2:0], 1'b0};
        lowy_r <= {lowy_r[CENTER_BITS-2:0], 1'b0};
        cnt_r  <= CNB'(cnt_r - 1'b1);
      end
      default: begin
      end
    endcase
  end

  assign out_res.valid        = (state_r == S_OUT);
  assign out_res.center_x     = satx_r ? '1 : qx_r;
  assign out_res.center_y     = saty_r ? '1 : qy_r;
  assign out_res.total_weight = OUT_WEIGHT_BITS'(w_r);
  assign out_res.empty_frame  = empty_r;

`ifndef SYNTH
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_res.valid && out_res.empty_frame) |->
      (out_res.center_x == '0 && out_res.center_y == '0 && out_res.total_weight == '0))
    else $error("empty frame with nonzero result fields");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (state_r == S_DIV || state_r == S_OUT))
    else $error("frame sums taken without starting a division");
`endif

endmodule

// File: rtl/core/image_intensity_centroid.sv
// image_intensity_centroid: intensity-weighted centroid of a raster frame
// one pixel per cycle while in_pix.ready is high; the back end holds one frame at a time
// last pixel to result valid: capture stage, product stage, queue, load, 20 divide steps
// up to 4 finished frames queue between accumulation and division
// reset: synchronous active-low rst_n clears sums, counters and queue, idles the divider;
// image width returns to 4096
`timescale 1ns / 1ps

module image_intensity_centroid import iic_pkg::*; #(
  parameter int PIXEL_BITS = 16,
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_BITS-1:0] cfg_wdata,
  iic_pix_if.sink             in_pix,
  iic_res_if.source           out_res
);

  localparam int WB     = PIXEL_BITS + 2 * COORD_BITS;
  localparam int MB     = WB + COORD_BITS;
  localparam int QW     = WB + 2 * MB;
  localparam int QDEPTH = 4;

  logic          q_push, q_pop, q_empty, q_full;
  logic [QW-1:0] q_wdata, q_rdata;

  iic_front #(
    .PIXEL_BITS (PIXEL_BITS),
    .COORD_BITS (COORD_BITS),
    .QDEPTH     (QDEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_pop     (q_pop),
    .q_push    (q_push),
    .q_wdata   (q_wdata),
    .in_pix    (in_pix)
  );

  iic_fifo #(
    .WIDTH (QW),
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (q_full)
  );

  iic_back #(
    .PIXEL_BITS (PIXEL_BITS),
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_rdata (q_rdata),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_res (out_res)
  );

`ifndef SYNTH
  a_full_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !in_pix.ready)
    else $error("input open while frame queue is full");
`endif

endmodule

// File: sim/tb_image_intensity_centroid.sv
// tb_image_intensity_centroid: self-checking bench for the intensity centroid block
// runs directed and random frames through a cycle-free centroid predictor under random stalls
// depends on iic_pkg, iic_if and image_intensity_centroid
`timescale 1ns / 1ps

module tb_image_intensity_centroid;
  import iic_pkg::*;

  localparam int COORD_BITS    = 12;
  localparam int FRAC_BITS     = 8;
  localparam int WEIGHT_BITS   = PIXEL_IN_BITS + 2 * COORD_BITS;
  localparam int MOMENT_BITS   = WEIGHT_BITS + COORD_BITS;
  localparam int MAX_SPAN      = 1 << COORD_BITS;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_PIXELS = 1000;
  localparam int TALL_PIXELS   = 200;
  localparam int HOLD_OFF      = 400;

  typedef struct packed {
    logic [CENTER_BITS-1:0]     center_x;
    logic [CENTER_BITS-1:0]     center_y;
    logic [OUT_WEIGHT_BITS-1:0] total_weight;
    logic                       empty_frame;
  } centroid_t;

  typedef enum int {PIX_FULL, PIX_ZERO, PIX_SMALL, PIX_EDGE} pixel_mix_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_BITS-1:0] cfg_wdata;

  iic_pix_if pix_if ();
  iic_res_if res_if ();

  image_intensity_centroid dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_pix    (pix_if),
    .out_res   (res_if)
  );

  // predictor state
  logic [CFG_BITS-1:0]    row_width;
  logic [WEIGHT_BITS-1:0] weight_acc;
  logic [MOMENT_BITS-1:0] moment_x_acc;
  logic [MOMENT_BITS-1:0] moment_y_acc;
  logic [COORD_BITS-1:0]  col_pos;
  logic [COORD_BITS-1:0]  row_pos;

  centroid_t pending_centroids[$];
  centroid_t observed;
  centroid_t predicted;

  int err_count     = 0;
  int pixels_sent   = 0;
  int frames_sent   = 0;
  int empty_frames  = 0;
  int results_seen  = 0;
  int width_writes  = 0;
  int quiet_cycles  = 0;
  bit sender_burst  = 1'b0;
  bit receiver_burst = 1'b0;
  bit hold_req      = 1'b0;
  int hold_cycles   = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void clear_frame();
    weight_acc   = '0;
    moment_x_acc = '0;
    moment_y_acc = '0;
    col_pos      = '0;
    row_pos      = '0;
  endfunction

  function automatic logic [CENTER_BITS-1:0] scale_center(logic [MOMENT_BITS-1:0] moment,
                                                         logic [WEIGHT_BITS-1:0] weight);
    logic [63:0] quot;
    quot = {moment, {FRAC_BITS{1'b0}}} / 64'(weight);
    if (quot > 64'((1 << CENTER_BITS) - 1)) return '1;
    return quot[CENTER_BITS-1:0];
  endfunction

  function automatic bit accumulate_pixel(input logic [PIXEL_IN_BITS-1:0] pix, input logic last,
                                          output centroid_t res);
    logic [CFG_BITS-1:0] span;
    res  = '0;
    span = row_width;
    if (span == '0) span = CFG_BITS'(1);
    if (span > CFG_BITS'(MAX_SPAN)) span = CFG_BITS'(MAX_SPAN);
    weight_acc   = weight_acc + WEIGHT_BITS'(pix);
    moment_x_acc = moment_x_acc + MOMENT_BITS'(pix) * MOMENT_BITS'(col_pos);
    moment_y_acc = moment_y_acc + MOMENT_BITS'(pix) * MOMENT_BITS'(row_pos);
    if (CFG_BITS'(col_pos) + CFG_BITS'(1) >= span) begin
      col_pos = '0;
      row_pos = row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    if (!last) return 1'b0;
    res.total_weight = OUT_WEIGHT_BITS'(weight_acc);
    if (weight_acc == '0) begin
      res.empty_frame = 1'b1;
    end else begin
      res.center_x = scale_center(moment_x_acc, weight_acc);
      res.center_y = scale_center(moment_y_acc, weight_acc);
    end
    clear_frame();
    return 1'b1;
  endfunction

  function automatic logic [PIXEL_IN_BITS-1:0] draw_pixel(pixel_mix_t mix);
    case (mix)
      PIX_ZERO:  return '0;
      PIX_SMALL: return PIXEL_IN_BITS'($urandom_range(0, 15));
      PIX_EDGE: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return '1;
          2:       return 16'h8000;
          default: return 16'h0001;
        endcase
      end
      default:   return PIXEL_IN_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_BITS-1:0] pick_width();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ($urandom_range(0, 1) == 0) ? '1 : CFG_BITS'($urandom_range(4097, 8191));
      2:       return CFG_BITS'(MAX_SPAN);
      3:       return CFG_BITS'($urandom_range(17, 4095));
      default: return CFG_BITS'($urandom_range(1, 16));
    endcase
  endfunction

  task automatic send_pixel(input logic [PIXEL_IN_BITS-1:0] pix, input logic last);
    int        gap;
    centroid_t res;
    gap = sender_burst ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      pix_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_if.valid       <= 1'b1;
    pix_if.pixel_value <= pix;
    pix_if.frame_last  <= last;
    do @(posedge clk); while (!pix_if.ready);
    pixels_sent++;
    if (accumulate_pixel(pix, last, res)) begin
      pending_centroids.push_back(res);
      frames_sent++;
      if (res.empty_frame) empty_frames++;
    end
  endtask

  task automatic send_frame(input int len, input pixel_mix_t mix, input bit close);
    for (int i = 0; i < len; i++) send_pixel(draw_pixel(mix), close && (i == len - 1));
  endtask

  task automatic wait_results();
    while (pending_centroids.size() != 0) @(posedge clk);
  endtask

  task automatic set_width(input logic [CFG_BITS-1:0] w);
    pix_if.valid <= 1'b0;
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we    <= 1'b0;
    row_width = w;
    width_writes++;
  endtask

  task automatic test_pixel_extremes();
    send_pixel('1, 1'b1);
    send_pixel('0, 1'b1);
    send_pixel('0, 1'b0);
    send_pixel('0, 1'b0);
    send_pixel('0, 1'b1);
    send_pixel('1, 1'b0);
    send_pixel(16'h0001, 1'b0);
    send_pixel(16'h8000, 1'b0);
    send_pixel('1, 1'b1);
  endtask

  task automatic test_width_limits();
    // zero width behaves as one pixel per row
    set_width('0);
    send_pixel(16'd10, 1'b0);
    send_pixel(16'd20, 1'b0);
    send_pixel('1, 1'b1);
    // widths above the coordinate range saturate
    set_width('1);
    send_pixel(16'd100, 1'b0);
    send_pixel(16'd200, 1'b1);
    set_width(CFG_BITS'(MAX_SPAN + 1));
    send_pixel(16'h5555, 1'b0);
    send_pixel(16'haaaa, 1'b1);
  endtask

  task automatic test_width_change();
    set_width(CFG_BITS'(8));
    send_frame(6, PIX_FULL, 1'b0);
    // column already past the new width wraps on the next request
    set_width(CFG_BITS'(3));
    send_frame(4, PIX_FULL, 1'b1);
  endtask

  task automatic test_tall_frame();
    set_width(CFG_BITS'(1));
    sender_burst = 1'b1;
    send_frame(TALL_PIXELS, PIX_FULL, 1'b1);
    sender_burst = 1'b0;
  endtask

  task automatic test_random_frames();
    int         start;
    int         len;
    int         head;
    int         pick;
    pixel_mix_t mix;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      if ($urandom_range(0, 3) == 0) set_width(pick_width());
      sender_burst   = ($urandom_range(0, 9) == 0);
      receiver_burst = ($urandom_range(0, 9) == 0);
      pick = $urandom_range(0, 9);
      mix  = (pick == 0) ? PIX_ZERO : (pick < 3) ? PIX_EDGE : (pick < 5) ? PIX_SMALL : PIX_FULL;
      len  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 40);
      if (len > 1 && $urandom_range(0, 19) == 0) begin
        head = $urandom_range(1, len - 1);
        send_frame(head, mix, 1'b0);
        set_width(pick_width());
        send_frame(len - head, mix, 1'b1);
      end else begin
        send_frame(len, mix, 1'b1);
      end
    end
    sender_burst   = 1'b0;
    receiver_burst = 1'b0;
  endtask

  task automatic test_output_stall();
    set_width(CFG_BITS'($urandom_range(1, 16)));
    hold_cycles  = HOLD_OFF;
    hold_req     = 1'b1;
    sender_burst = 1'b1;
    for (int i = 0; i < 40; i++) send_frame($urandom_range(1, 3), PIX_FULL, 1'b1);
    sender_burst = 1'b0;
  endtask

  task automatic test_sender_pause();
    for (int i = 0; i < 3; i++) send_frame($urandom_range(1, 12), PIX_FULL, 1'b1);
    pix_if.valid <= 1'b0;
    wait_results();
    for (int i = 0; i < 3; i++) send_frame($urandom_range(1, 12), PIX_FULL, 1'b1);
  endtask

  task automatic report_mismatch(input string what, input centroid_t want, input centroid_t got);
    err_count++;
    if (err_count <= 10)
      $display("%0t %s: expected x=%h y=%h w=%h empty=%b, got x=%h y=%h w=%h empty=%b",
               $realtime, what, want.center_x, want.center_y, want.total_weight,
               want.empty_frame, got.center_x, got.center_y, got.total_weight, got.empty_frame);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && res_if.valid && res_if.ready) begin
      observed = {res_if.center_x, res_if.center_y, res_if.total_weight, res_if.empty_frame};
      results_seen++;
      if (pending_centroids.size() == 0) begin
        report_mismatch("unexpected result", '0, observed);
      end else begin
        predicted = pending_centroids.pop_front();
        if (observed !== predicted) report_mismatch("centroid mismatch", predicted, observed);
      end
    end
  end

  // result receiver with random and long stalls
  initial begin
    int gap;
    res_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = receiver_burst ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!(res_if.valid && res_if.ready) && !hold_req);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no request moved for %0d cycles, %0d results outstanding",
               quiet_cycles, pending_centroids.size());
      $display("tb_image_intensity_centroid: done, errors");
      $finish;
    end
  end

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    pix_if.valid       <= 1'b0;
    pix_if.pixel_value <= '0;
    pix_if.frame_last  <= 1'b0;
    row_width = WIDTH_RESET;
    clear_frame();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_pixel_extremes();
    test_width_limits();
    test_width_change();
    test_random_frames();
    test_output_stall();
    test_sender_pause();
    test_tall_frame();

    pix_if.valid <= 1'b0;
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d pixels in %0d frames (%0d empty), %0d results, %0d width writes",
             pixels_sent, frames_sent, empty_frames, results_seen, width_writes);
    $display("incl. zero and oversize widths, mid-frame width change, tall single-column frame,");
    $display("long output stall with a full queue and a sender pause until drained");
    if (err_count == 0) begin
      $display("tb_image_intensity_centroid: done, clean");
    end else begin
      $display("mismatches: %0d", err_count);
      $display("tb_image_intensity_centroid: done, errors");
    end
    $finish;
  end

endmodule
